[rtl/assert_macros.svh]
// Assertion macros shared by the job dispatcher RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define JDPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define JDPQ_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/jdpq_pkg.sv]
// Types and constants of the job dispatcher.
// No dependencies; used by jdpq_idle_fifo and the top level of the block.
package jdpq_pkg;

    localparam int KIND_W  = 3;
    localparam int ID_W    = 8;
    localparam int WID_W   = 5;
    localparam int WC_W    = 6;
    localparam int ABT_W   = 6;
    localparam int TOT_W   = 9;

    localparam logic [WC_W-1:0] WC_RESET = 6'd4;

    localparam logic [KIND_W-1:0] KIND_SUBMIT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READY     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ABORT     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ABORT_ALL = 3'd4;

    localparam int JS_W = 2;
    localparam logic [JS_W-1:0] JS_FREE   = 2'd0;
    localparam logic [JS_W-1:0] JS_QUEUED = 2'd1;
    localparam logic [JS_W-1:0] JS_DISP   = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_DISP_RD,
        ST_DISP_WR,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_CLR_RD,
        ST_CLR_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic [WID_W-1:0] worker;
    } t_idle_cmd;

endpackage

[rtl/jdpq_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module jdpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/jdpq_idle_fifo.sv]
// Circular FIFO of idle worker ids held in flip-flops.
// Depends on jdpq_pkg for the command struct.
module jdpq_idle_fifo #(
    parameter int MAX_WORKERS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  jdpq_pkg::t_idle_cmd                i_cmd,
    output logic [jdpq_pkg::WID_W-1:0]         o_head,
    output logic [$clog2(MAX_WORKERS+1)-1:0]   o_count
);

    localparam int PW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CW = $clog2(MAX_WORKERS + 1);

    logic [jdpq_pkg::WID_W-1:0] r_mem [MAX_WORKERS];
    logic [PW-1:0]              r_head;
    logic [PW-1:0]              n_head;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic [CW:0]                tail_sum;
    logic [PW-1:0]              tail;
    logic                       do_push;
    logic                       do_pop;

    assign do_push = i_cmd.push && (r_count < CW'(MAX_WORKERS));
    assign do_pop  = i_cmd.pop && (r_count != '0);

    always_comb begin
        tail_sum = (CW+1)'(r_head) + (CW+1)'(r_count);
        if (tail_sum >= (CW+1)'(MAX_WORKERS)) begin
            tail_sum = tail_sum - (CW+1)'(MAX_WORKERS);
        end
        tail = PW'(tail_sum);
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (do_pop) begin
            n_head = (r_head == PW'(MAX_WORKERS - 1)) ? '0 : r_head + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[tail] <= i_cmd.worker;
        end
    end

    assign o_head  = r_mem[r_head];
    assign o_count = r_count;

endmodule

[rtl/job_dispatcher_with_priority_queue_core.sv]
// Top level of the job dispatcher: control sequencer, pending deque and job state.
// Depends on jdpq_pkg, jdpq_ram, jdpq_idle_fifo and assert_macros.svh.
// Every event returns exactly one result on the output channel.
`include "assert_macros.svh"

// Job dispatcher. Events arrive one at a time on the input channel and each
// returns one result. Pending jobs sit in a circular deque in one RAM, the
// state of every job id (free, queued, dispatched) in a second RAM, and idle
// workers in a small flip-flop FIFO. Since every RAM read is registered, the
// sequencer gives each RAM access a state of its own. A rejected submit, an
// abort that misses, an abort-all on an empty queue or an ignored kind goes
// from the decision straight to the result; a submit, ready or finish event
// also tries to dispatch the head of the queue to an idle worker.
// An abort that finds its job reads and compares each entry up to it, then
// moves each entry behind it forward one place; an abort-all reads each
// queued entry and frees its job state. The result waits while the last one
// is still on the output. After reset the job state RAM is cleared entry by
// entry, with no event taken; configuration writes are taken at any time.
module job_dispatcher_with_priority_queue_core #(
    parameter int QUEUE_DEPTH = 32,
    parameter int MAX_WORKERS = 32,
    parameter int JOB_IDS     = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [jdpq_pkg::WC_W-1:0]     i_cfg_worker_count,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [jdpq_pkg::KIND_W-1:0]   i_kind,
    input  logic [jdpq_pkg::ID_W-1:0]     i_job_id,
    input  logic [jdpq_pkg::WID_W-1:0]    i_worker_id,
    input  logic                          i_urgent,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_accepted,
    output logic                          o_dispatch_valid,
    output logic [jdpq_pkg::ID_W-1:0]     o_dispatch_job,
    output logic [jdpq_pkg::WID_W-1:0]    o_dispatch_worker,
    output logic [jdpq_pkg::ABT_W-1:0]    o_aborted_count,
    output logic [jdpq_pkg::TOT_W-1:0]    o_completed_count,
    output logic [jdpq_pkg::TOT_W-1:0]    o_submitted_count,
    output logic                          o_all_done
);

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int JAW = $clog2(JOB_IDS);
    localparam int JXW = (JAW > jdpq_pkg::ID_W) ? JAW : jdpq_pkg::ID_W;
    localparam int ICW = $clog2(MAX_WORKERS + 1);
    localparam int IW  = jdpq_pkg::ID_W;
    localparam int WW  = jdpq_pkg::WID_W;
    localparam int TW  = jdpq_pkg::TOT_W;
    localparam int AW  = jdpq_pkg::ABT_W;

    function automatic logic [QAW-1:0] q_at(input logic [QAW-1:0] head,
                                            input logic [QCW-1:0] off);
        logic [QCW:0] s;
        s = (QCW+1)'(head) + (QCW+1)'(off);
        if (s >= (QCW+1)'(QUEUE_DEPTH)) begin
            s = s - (QCW+1)'(QUEUE_DEPTH);
        end
        return QAW'(s);
    endfunction

    function automatic logic [QAW-1:0] q_dec(input logic [QAW-1:0] p);
        return (p == '0) ? QAW'(QUEUE_DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic [JAW-1:0] to_jaddr(input logic [IW-1:0] id);
        logic [JXW-1:0] x;
        x = JXW'(id);
        return x[JAW-1:0];
    endfunction

    jdpq_pkg::t_state r_state;
    jdpq_pkg::t_state n_state;

    logic [JAW-1:0]               r_clr, n_clr;
    logic [jdpq_pkg::WC_W-1:0]    r_wc, n_wc;
    logic [jdpq_pkg::KIND_W-1:0]  r_kind, n_kind;
    logic [IW-1:0]                r_id, n_id;
    logic [WW-1:0]                r_wid, n_wid;
    logic                         r_hp, n_hp;
    logic [QAW-1:0]               r_qhead, n_qhead;
    logic [QCW-1:0]               r_qcount, n_qcount;
    logic [QCW-1:0]               r_scan, n_scan;
    logic [TW-1:0]                r_sub, n_sub;
    logic [TW-1:0]                r_comp, n_comp;

    logic                         r_res_acc, n_res_acc;
    logic                         r_res_dv, n_res_dv;
    logic [IW-1:0]                r_res_job, n_res_job;
    logic [WW-1:0]                r_res_wkr, n_res_wkr;
    logic [AW-1:0]                r_res_abt, n_res_abt;
    logic [TW-1:0]                r_res_comp, n_res_comp;
    logic [TW-1:0]                r_res_sub, n_res_sub;
    logic                         r_res_done, n_res_done;

    logic                         r_out_valid, n_out_valid;
    logic                         r_o_acc, n_o_acc;
    logic                         r_o_dv, n_o_dv;
    logic [IW-1:0]                r_o_job, n_o_job;
    logic [WW-1:0]                r_o_wkr, n_o_wkr;
    logic [AW-1:0]                r_o_abt, n_o_abt;
    logic [TW-1:0]                r_o_comp, n_o_comp;
    logic [TW-1:0]                r_o_sub, n_o_sub;
    logic                         r_o_done, n_o_done;

    logic [TW-1:0]                s_sub;
    logic [TW-1:0]                s_comp;
    logic                         s_settle;
    logic                         id_ok;
    logic [QCW:0]                 scan_next;

    logic                         jm_we;
    logic [JAW-1:0]               jm_waddr;
    logic [jdpq_pkg::JS_W-1:0]    jm_wdata;
    logic                         jm_re;
    logic [JAW-1:0]               jm_raddr;
    logic [jdpq_pkg::JS_W-1:0]    jm_rdata;

    logic                         qm_we;
    logic [QAW-1:0]               qm_waddr;
    logic [IW-1:0]                qm_wdata;
    logic                         qm_re;
    logic [QAW-1:0]               qm_raddr;
    logic [IW-1:0]                qm_rdata;

    jdpq_pkg::t_idle_cmd          idle_cmd;
    logic [WW-1:0]                idle_head;
    logic [ICW-1:0]               idle_count;

    jdpq_ram #(
        .WIDTH (jdpq_pkg::JS_W),
        .DEPTH (JOB_IDS)
    ) u_job_ram (
        .i_clk   (i_clk),
        .i_we    (jm_we),
        .i_waddr (jm_waddr),
        .i_wdata (jm_wdata),
        .i_re    (jm_re),
        .i_raddr (jm_raddr),
        .o_rdata (jm_rdata)
    );

    jdpq_ram #(
        .WIDTH (IW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (qm_we),
        .i_waddr (qm_waddr),
        .i_wdata (qm_wdata),
        .i_re    (qm_re),
        .i_raddr (qm_raddr),
        .o_rdata (qm_rdata)
    );

    jdpq_idle_fifo #(
        .MAX_WORKERS (MAX_WORKERS)
    ) u_idle_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (idle_cmd),
        .o_head  (idle_head),
        .o_count (idle_count)
    );

    assign id_ok     = (32'(r_id) < JOB_IDS);
    assign scan_next = (QCW+1)'(r_scan) + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jdpq_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_wc        = r_wc;
        n_kind      = r_kind;
        n_id        = r_id;
        n_wid       = r_wid;
        n_hp        = r_hp;
        n_qhead     = r_qhead;
        n_qcount    = r_qcount;
        n_scan      = r_scan;
        n_sub       = r_sub;
        n_comp      = r_comp;
        n_res_acc   = r_res_acc;
        n_res_dv    = r_res_dv;
        n_res_job   = r_res_job;
        n_res_wkr   = r_res_wkr;
        n_res_abt   = r_res_abt;
        n_res_comp  = r_res_comp;
        n_res_sub   = r_res_sub;
        n_res_done  = r_res_done;
        n_out_valid = r_out_valid;
        n_o_acc     = r_o_acc;
        n_o_dv      = r_o_dv;
        n_o_job     = r_o_job;
        n_o_wkr     = r_o_wkr;
        n_o_abt     = r_o_abt;
        n_o_comp    = r_o_comp;
        n_o_sub     = r_o_sub;
        n_o_done    = r_o_done;
        s_sub       = r_sub;
        s_comp      = r_comp;
        s_settle    = 1'b0;
        jm_we       = 1'b0;
        jm_waddr    = '0;
        jm_wdata    = jdpq_pkg::JS_FREE;
        jm_re       = 1'b0;
        jm_raddr    = '0;
        qm_we       = 1'b0;
        qm_waddr    = '0;
        qm_wdata    = r_id;
        qm_re       = 1'b0;
        qm_raddr    = '0;
        idle_cmd    = '0;
        o_in_ready  = 1'b0;

        if (i_cfg_valid) begin
            n_wc = i_cfg_worker_count;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            jdpq_pkg::ST_CLEAR: begin
                jm_we    = 1'b1;
                jm_waddr = r_clr;
                if (r_clr == JAW'(JOB_IDS - 1)) begin
                    n_state = jdpq_pkg::ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            jdpq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_kind   = i_kind;
                    n_id     = i_job_id;
                    n_wid    = i_worker_id;
                    n_hp     = i_urgent;
                    jm_re    = 1'b1;
                    jm_raddr = to_jaddr(i_job_id);
                    n_state  = jdpq_pkg::ST_DECIDE;
                end
            end
            jdpq_pkg::ST_DECIDE: begin
                n_res_acc  = 1'b0;
                n_res_dv   = 1'b0;
                n_res_job  = '0;
                n_res_wkr  = '0;
                n_res_abt  = '0;
                n_res_comp = r_comp;
                n_res_sub  = r_sub;
                n_res_done = 1'b0;
                n_scan     = '0;
                n_state    = jdpq_pkg::ST_DONE;
                case (r_kind)
                    jdpq_pkg::KIND_SUBMIT: begin
                        if (r_wc != '0 && r_qcount < QCW'(QUEUE_DEPTH) && id_ok &&
                            jm_rdata == jdpq_pkg::JS_FREE) begin
                            qm_we = 1'b1;
                            if (r_hp) begin
                                qm_waddr = q_dec(r_qhead);
                                n_qhead  = q_dec(r_qhead);
                            end else begin
                                qm_waddr = q_at(r_qhead, r_qcount);
                            end
                            n_qcount  = r_qcount + 1'b1;
                            jm_we     = 1'b1;
                            jm_waddr  = to_jaddr(r_id);
                            jm_wdata  = jdpq_pkg::JS_QUEUED;
                            n_res_acc = 1'b1;
                            s_sub     = r_sub + 1'b1;
                            s_settle  = 1'b1;
                            n_state   = jdpq_pkg::ST_DISP_RD;
                        end
                    end
                    jdpq_pkg::KIND_READY: begin
                        idle_cmd.push   = 1'b1;
                        idle_cmd.worker = r_wid;
                        n_state         = jdpq_pkg::ST_DISP_RD;
                    end
                    jdpq_pkg::KIND_FINISH: begin
                        idle_cmd.push   = 1'b1;
                        idle_cmd.worker = r_wid;
                        if (id_ok && jm_rdata == jdpq_pkg::JS_DISP) begin
                            jm_we    = 1'b1;
                            jm_waddr = to_jaddr(r_id);
                            s_comp   = r_comp + 1'b1;
                            s_settle = 1'b1;
                        end
                        n_state = jdpq_pkg::ST_DISP_RD;
                    end
                    jdpq_pkg::KIND_ABORT: begin
                        if (id_ok && jm_rdata == jdpq_pkg::JS_QUEUED) begin
                            jm_we     = 1'b1;
                            jm_waddr  = to_jaddr(r_id);
                            n_res_acc = 1'b1;
                            n_res_abt = AW'(1);
                            s_comp    = r_comp + 1'b1;
                            s_settle  = 1'b1;
                            n_state   = jdpq_pkg::ST_SRCH_RD;
                        end
                    end
                    jdpq_pkg::KIND_ABORT_ALL: begin
                        if (r_qcount != '0) begin
                            n_res_acc = 1'b1;
                            n_res_abt = AW'(r_qcount);
                            s_comp    = r_comp + TW'(r_qcount);
                            s_settle  = 1'b1;
                            n_state   = jdpq_pkg::ST_CLR_RD;
                        end
                    end
                    default: begin
                    end
                endcase
                if (s_settle) begin
                    n_res_comp = s_comp;
                    n_res_sub  = s_sub;
                    if (s_sub == s_comp) begin
                        n_sub      = '0;
                        n_comp     = '0;
                        n_res_done = 1'b1;
                    end else begin
                        n_sub  = s_sub;
                        n_comp = s_comp;
                    end
                end
            end
            jdpq_pkg::ST_DISP_RD: begin
                if (idle_count != '0 && r_qcount != '0) begin
                    qm_re        = 1'b1;
                    qm_raddr     = r_qhead;
                    idle_cmd.pop = 1'b1;
                    n_res_wkr    = idle_head;
                    n_qhead      = q_at(r_qhead, QCW'(1));
                    n_qcount     = r_qcount - 1'b1;
                    n_state      = jdpq_pkg::ST_DISP_WR;
                end else begin
                    n_state = jdpq_pkg::ST_DONE;
                end
            end
            jdpq_pkg::ST_DISP_WR: begin
                n_res_dv  = 1'b1;
                n_res_job = qm_rdata;
                jm_we     = 1'b1;
                jm_waddr  = to_jaddr(qm_rdata);
                jm_wdata  = jdpq_pkg::JS_DISP;
                n_state   = jdpq_pkg::ST_DONE;
            end
            jdpq_pkg::ST_SRCH_RD: begin
                if (r_scan < r_qcount) begin
                    qm_re    = 1'b1;
                    qm_raddr = q_at(r_qhead, r_scan);
                    n_state  = jdpq_pkg::ST_SRCH_CMP;
                end else begin
                    n_state = jdpq_pkg::ST_DONE;
                end
            end
            jdpq_pkg::ST_SRCH_CMP: begin
                if (qm_rdata == r_id) begin
                    n_state = jdpq_pkg::ST_SH_RD;
                end else begin
                    n_scan  = r_scan + 1'b1;
                    n_state = jdpq_pkg::ST_SRCH_RD;
                end
            end
            jdpq_pkg::ST_SH_RD: begin
                if (scan_next < (QCW+1)'(r_qcount)) begin
                    qm_re    = 1'b1;
                    qm_raddr = q_at(r_qhead, QCW'(scan_next));
                    n_state  = jdpq_pkg::ST_SH_WR;
                end else begin
                    n_qcount = r_qcount - 1'b1;
                    n_state  = jdpq_pkg::ST_DONE;
                end
            end
            jdpq_pkg::ST_SH_WR: begin
                qm_we    = 1'b1;
                qm_waddr = q_at(r_qhead, r_scan);
                qm_wdata = qm_rdata;
                n_scan   = r_scan + 1'b1;
                n_state  = jdpq_pkg::ST_SH_RD;
            end
            jdpq_pkg::ST_CLR_RD: begin
                if (r_scan < r_qcount) begin
                    qm_re    = 1'b1;
                    qm_raddr = q_at(r_qhead, r_scan);
                    n_state  = jdpq_pkg::ST_CLR_WR;
                end else begin
                    n_qcount = '0;
                    n_state  = jdpq_pkg::ST_DONE;
                end
            end
            jdpq_pkg::ST_CLR_WR: begin
                jm_we    = 1'b1;
                jm_waddr = to_jaddr(qm_rdata);
                n_scan   = r_scan + 1'b1;
                n_state  = jdpq_pkg::ST_CLR_RD;
            end
            jdpq_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_acc     = r_res_acc;
                    n_o_dv      = r_res_dv;
                    n_o_job     = r_res_job;
                    n_o_wkr     = r_res_wkr;
                    n_o_abt     = r_res_abt;
                    n_o_comp    = r_res_comp;
                    n_o_sub     = r_res_sub;
                    n_o_done    = r_res_done;
                    n_state     = jdpq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = jdpq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_wc        <= jdpq_pkg::WC_RESET;
            r_qhead     <= '0;
            r_qcount    <= '0;
            r_sub       <= '0;
            r_comp      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr       <= n_clr;
            r_wc        <= n_wc;
            r_qhead     <= n_qhead;
            r_qcount    <= n_qcount;
            r_sub       <= n_sub;
            r_comp      <= n_comp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_id       <= n_id;
        r_wid      <= n_wid;
        r_hp       <= n_hp;
        r_scan     <= n_scan;
        r_res_acc  <= n_res_acc;
        r_res_dv   <= n_res_dv;
        r_res_job  <= n_res_job;
        r_res_wkr  <= n_res_wkr;
        r_res_abt  <= n_res_abt;
        r_res_comp <= n_res_comp;
        r_res_sub  <= n_res_sub;
        r_res_done <= n_res_done;
        r_o_acc    <= n_o_acc;
        r_o_dv     <= n_o_dv;
        r_o_job    <= n_o_job;
        r_o_wkr    <= n_o_wkr;
        r_o_abt    <= n_o_abt;
        r_o_comp   <= n_o_comp;
        r_o_sub    <= n_o_sub;
        r_o_done   <= n_o_done;
    end

    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_accepted        = r_o_acc;
    assign o_dispatch_valid  = r_o_dv;
    assign o_dispatch_job    = r_o_job;
    assign o_dispatch_worker = r_o_wkr;
    assign o_aborted_count   = r_o_abt;
    assign o_completed_count = r_o_comp;
    assign o_submitted_count = r_o_sub;
    assign o_all_done        = r_o_done;

    `JDPQ_ASSERT_RST(a_reset_clears, !i_rst_n |=> (r_state == jdpq_pkg::ST_CLEAR && !r_out_valid), "reset must restart the clearing pass")
    `JDPQ_ASSERT(a_queue_bound, r_qcount <= QCW'(QUEUE_DEPTH), "pending count above queue depth")
    `JDPQ_ASSERT(a_accept_decides, (i_in_valid && o_in_ready) |=> (r_state == jdpq_pkg::ST_DECIDE), "transfer not followed by decision")
    `JDPQ_ASSERT(a_done_equal, (r_out_valid && r_o_done) |-> (r_o_comp == r_o_sub), "all_done with unequal totals")

endmodule
